FILE: hw/rtl/stxcr_pkg.sv
`default_nettype none
package stxcr_pkg;

  // Frame store geometry
  localparam int BUF_SIZE = 64;
  localparam int ADDR_W   = $clog2(BUF_SIZE);
  localparam int IDX_W    = $clog2(BUF_SIZE + 1);

  // Field widths
  localparam int OP_W      = 2;
  localparam int BYTE_W    = 8;
  localparam int EV_W      = 3;
  localparam int NIB_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;
  localparam int TMR_W     = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 1'd1;
  localparam logic [TMR_W-1:0]     TIMEOUT_RST    = 16'd1000;

  // Item operation codes
  localparam logic [OP_W-1:0] OP_BYTE = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK = 2'd1;
  localparam logic [OP_W-1:0] OP_LERR = 2'd2;

  // Line characters
  localparam logic [BYTE_W-1:0] CH_STX = 8'h02;
  localparam logic [BYTE_W-1:0] CH_ACK = 8'h06;
  localparam logic [BYTE_W-1:0] CH_NAK = 8'h15;
  localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;

  // Frame layout
  localparam logic [IDX_W-1:0]  MIN_FRAME   = IDX_W'(9);
  localparam logic [IDX_W-1:0]  CHK_END_OFS = IDX_W'(4);
  localparam logic [IDX_W-1:0]  PAY_END_OFS = IDX_W'(5);
  localparam logic [IDX_W-1:0]  RHI_OFS     = IDX_W'(3);
  localparam logic [IDX_W-1:0]  RLO_OFS     = IDX_W'(2);
  localparam logic [ADDR_W-1:0] KIND_HI_POS = ADDR_W'(3 % BUF_SIZE);
  localparam logic [ADDR_W-1:0] KIND_LO_POS = ADDR_W'(4 % BUF_SIZE);

  // Result event codes
  localparam logic [EV_W-1:0] EV_ACK      = 3'd0;
  localparam logic [EV_W-1:0] EV_NAK      = 3'd1;
  localparam logic [EV_W-1:0] EV_PAYLOAD  = 3'd2;
  localparam logic [EV_W-1:0] EV_CHECK    = 3'd3;
  localparam logic [EV_W-1:0] EV_KIND     = 3'd4;
  localparam logic [EV_W-1:0] EV_SHORT    = 3'd5;
  localparam logic [EV_W-1:0] EV_OVERFLOW = 3'd6;
  localparam logic [EV_W-1:0] EV_TIMEOUT  = 3'd7;

  // Read address selects
  localparam logic [2:0] RS_IDX = 3'd0;
  localparam logic [2:0] RS_RHI = 3'd1;
  localparam logic [2:0] RS_RLO = 3'd2;
  localparam logic [2:0] RS_KHI = 3'd3;
  localparam logic [2:0] RS_KLO = 3'd4;

  // Read data capture targets
  localparam logic [2:0] CAP_NONE = 3'd0;
  localparam logic [2:0] CAP_RHI  = 3'd1;
  localparam logic [2:0] CAP_RLO  = 3'd2;
  localparam logic [2:0] CAP_KHI  = 3'd3;
  localparam logic [2:0] CAP_KLO  = 3'd4;

  // Enabled kind ids, row = high nibble, bit = low nibble
  localparam logic [15:0] KIND_EN [16] = '{
    16'h003E, 16'h03FF, 16'h03FF, 16'h03FF, 16'h03FF, 16'h007F, 16'h00FF, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000
  };

  typedef struct packed {
    logic             accept;
    logic             rd_en;
    logic [2:0]       rd_sel;
    logic             sum_rd;
    logic [2:0]       cap;
    logic             idx_clr;
    logic             idx_inc;
    logic             out_single;
    logic [EV_W-1:0]  out_ev;
    logic             out_payload;
  } cmd_t;

  typedef struct packed {
    logic            finish;
    logic            out_free;
    logic            short_frame;
    logic            sum_last;
    logic            mismatch;
    logic            kind_bad;
    logic            pay_last;
  } sts_t;

  // ASCII hex digit to value; anything else reads as zero
  function automatic logic [NIB_W-1:0] hex_val(input logic [BYTE_W-1:0] c);
    logic [NIB_W-1:0] v;
    v = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[NIB_W-1:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = NIB_W'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = NIB_W'(c - 8'h57);
    end
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/stxcr_if.sv
`default_nettype none
interface stxcr_item_if;
  logic                          valid;
  logic                          ready;
  logic [stxcr_pkg::OP_W-1:0]    op;
  logic [stxcr_pkg::BYTE_W-1:0]  rx_byte;
  modport source (output valid, op, rx_byte, input ready);
  modport sink   (input valid, op, rx_byte, output ready);
endinterface

interface stxcr_res_if;
  logic                          valid;
  logic                          ready;
  logic [stxcr_pkg::EV_W-1:0]    event_res;
  logic [stxcr_pkg::BYTE_W-1:0]  payload_byte;
  logic [stxcr_pkg::BYTE_W-1:0]  kind_id;
  logic                          last;
  modport source (output valid, event_res, payload_byte, kind_id, last, input ready);
  modport sink   (input valid, event_res, payload_byte, kind_id, last, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/stxcr_ram.sv
`default_nettype none
module stxcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: hw/rtl/stxcr_ctrl.sv
`default_nettype none
module stxcr_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  stxcr_pkg::sts_t sts_i,
  output stxcr_pkg::cmd_t cmd_o
);
  import stxcr_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FIN    = 4'd1;
  localparam logic [3:0] S_SUM    = 4'd2;
  localparam logic [3:0] S_RH     = 4'd3;
  localparam logic [3:0] S_RL     = 4'd4;
  localparam logic [3:0] S_KH     = 4'd5;
  localparam logic [3:0] S_KL     = 4'd6;
  localparam logic [3:0] S_CMP    = 4'd7;
  localparam logic [3:0] S_SINGLE = 4'd8;
  localparam logic [3:0] S_PRD    = 4'd9;
  localparam logic [3:0] S_PLD    = 4'd10;

  logic [3:0]      state_q, state_d;
  logic [EV_W-1:0] ev_q, ev_d;
  logic            in_ready;

  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    ev_d     = ev_q;
    in_ready = (state_q == S_IDLE) && sts_i.out_free;
    cmd_o.accept = in_valid_i && in_ready;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.accept && sts_i.finish) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (sts_i.short_frame) begin
          ev_d    = EV_SHORT;
          state_d = S_SINGLE;
        end else begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_SUM;
        end
      end
      S_SUM: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RS_IDX;
        cmd_o.sum_rd = 1'b1;
        if (sts_i.sum_last) begin
          state_d = S_RH;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_RH: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RS_RHI;
        state_d      = S_RL;
      end
      S_RL: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RS_RLO;
        cmd_o.cap    = CAP_RHI;
        state_d      = S_KH;
      end
      S_KH: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RS_KHI;
        cmd_o.cap    = CAP_RLO;
        state_d      = S_KL;
      end
      S_KL: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RS_KLO;
        cmd_o.cap    = CAP_KHI;
        state_d      = S_CMP;
      end
      S_CMP: begin
        cmd_o.cap = CAP_KLO;
        if (sts_i.mismatch) begin
          ev_d    = EV_CHECK;
          state_d = S_SINGLE;
        end else if (sts_i.kind_bad) begin
          ev_d    = EV_KIND;
          state_d = S_SINGLE;
        end else begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_PRD;
        end
      end
      S_SINGLE: begin
        if (sts_i.out_free) begin
          cmd_o.out_single = 1'b1;
          cmd_o.out_ev     = ev_q;
          state_d          = S_IDLE;
        end
      end
      S_PRD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RS_IDX;
        state_d      = S_PLD;
      end
      S_PLD: begin
        if (sts_i.out_free) begin
          cmd_o.out_payload = 1'b1;
          if (sts_i.pay_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_PRD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ev_q    <= EV_ACK;
    end else begin
      state_q <= state_d;
      ev_q    <= ev_d;
    end
  end

  assign in_ready_o = in_ready;

endmodule
`default_nettype wire

FILE: hw/rtl/stxcr_dpath.sv
`default_nettype none
module stxcr_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [stxcr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [stxcr_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic [stxcr_pkg::OP_W-1:0]    op_i,
  input  logic [stxcr_pkg::BYTE_W-1:0]  rx_byte_i,
  input  stxcr_pkg::cmd_t               cmd_i,
  output stxcr_pkg::sts_t               sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [stxcr_pkg::EV_W-1:0]    event_res_o,
  output logic [stxcr_pkg::BYTE_W-1:0]  payload_byte_o,
  output logic [stxcr_pkg::BYTE_W-1:0]  kind_id_o,
  output logic                          last_o
);
  import stxcr_pkg::*;

  // Configuration
  logic             mode_q;
  logic [TMR_W-1:0] tmo_q;

  // Frame tracking
  logic             rcv_q, rcv_d;
  logic [IDX_W-1:0] wi_q, wi_d;
  logic [TMR_W-1:0] tmr_q, tmr_d;
  logic [IDX_W-1:0] n_q, n_d;
  logic [TMR_W-1:0] tmr_inc;

  // Item decision
  logic             item_emit;
  logic [EV_W-1:0]  item_ev;
  logic             item_fin;
  logic             we;
  logic [ADDR_W-1:0] waddr;

  // Check walk
  logic [IDX_W-1:0]  idx_q;
  logic              sum_pend_q;
  logic [BYTE_W-1:0] calc_q;
  logic [NIB_W-1:0]  rhi_q, khi_q;
  logic [BYTE_W-1:0] recv_q, kind_q;
  logic [NIB_W-1:0]  rd_nib;
  logic [ADDR_W-1:0] raddr;
  logic [BYTE_W-1:0] rdata;

  // Result register
  logic              ov_q;
  logic [EV_W-1:0]   oev_q;
  logic [BYTE_W-1:0] opay_q, okind_q;
  logic              olast_q;

  assign tmr_inc = tmr_q + TMR_W'(1);

  always_comb begin
    rcv_d     = rcv_q;
    wi_d      = wi_q;
    tmr_d     = tmr_q;
    n_d       = n_q;
    item_emit = 1'b0;
    item_ev   = EV_ACK;
    item_fin  = 1'b0;
    we        = 1'b0;
    waddr     = wi_q[ADDR_W-1:0];
    unique case (op_i)
      OP_LERR: begin
        rcv_d = 1'b0;
        wi_d  = '0;
        tmr_d = '0;
      end
      OP_TICK: begin
        if (rcv_q) begin
          tmr_d = tmr_inc;
          if (tmr_inc >= tmo_q) begin
            rcv_d     = 1'b0;
            wi_d      = '0;
            tmr_d     = '0;
            item_emit = 1'b1;
            item_ev   = EV_TIMEOUT;
          end
        end
      end
      OP_BYTE: begin
        if (!rcv_q) begin
          wi_d  = '0;
          tmr_d = '0;
          if (rx_byte_i == CH_STX) begin
            we    = 1'b1;
            waddr = '0;
            wi_d  = IDX_W'(1);
            rcv_d = 1'b1;
          end else if (rx_byte_i == CH_ACK) begin
            item_emit = 1'b1;
            item_ev   = EV_ACK;
          end else if (rx_byte_i == CH_NAK) begin
            item_emit = 1'b1;
            item_ev   = EV_NAK;
          end
        end else if (wi_q >= IDX_W'(BUF_SIZE)) begin
          rcv_d     = 1'b0;
          wi_d      = '0;
          tmr_d     = '0;
          item_emit = 1'b1;
          item_ev   = EV_OVERFLOW;
        end else begin
          we   = 1'b1;
          wi_d = wi_q + IDX_W'(1);
          if (rx_byte_i == CH_CR) begin
            // Latch the frame length and drop back to idle; the walk runs off n
            n_d      = wi_q + IDX_W'(1);
            item_fin = 1'b1;
            rcv_d    = 1'b0;
            wi_d     = '0;
            tmr_d    = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    unique case (cmd_i.rd_sel)
      RS_IDX:  raddr = idx_q[ADDR_W-1:0];
      RS_RHI:  raddr = ADDR_W'(n_q - RHI_OFS);
      RS_RLO:  raddr = ADDR_W'(n_q - RLO_OFS);
      RS_KHI:  raddr = KIND_HI_POS;
      RS_KLO:  raddr = KIND_LO_POS;
      default: raddr = idx_q[ADDR_W-1:0];
    endcase
  end

  stxcr_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(BUF_SIZE)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.accept && we),
    .waddr_i(waddr),
    .wdata_i(rx_byte_i),
    .re_i   (cmd_i.rd_en),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd_nib = hex_val(rdata);

  assign sts_o.finish      = item_fin;
  assign sts_o.out_free    = !ov_q || out_ready_i;
  assign sts_o.short_frame = n_q < MIN_FRAME;
  assign sts_o.sum_last    = idx_q == (n_q - CHK_END_OFS);
  assign sts_o.mismatch    = calc_q != recv_q;
  assign sts_o.kind_bad    = !KIND_EN[khi_q][rd_nib];
  assign sts_o.pay_last    = idx_q == (n_q - PAY_END_OFS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      tmo_q      <= TIMEOUT_RST;
      rcv_q      <= 1'b0;
      wi_q       <= '0;
      tmr_q      <= '0;
      n_q        <= '0;
      idx_q      <= '0;
      sum_pend_q <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_CHECK_MODE: mode_q <= cfg_data_i[0];
          CFG_TIMEOUT:    tmo_q  <= cfg_data_i[TMR_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.accept) begin
        rcv_q <= rcv_d;
        wi_q  <= wi_d;
        tmr_q <= tmr_d;
        n_q   <= n_d;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= IDX_W'(1);
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      sum_pend_q <= cmd_i.sum_rd;
      if ((cmd_i.accept && item_emit) || cmd_i.out_single || cmd_i.out_payload) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Walk payload: accumulator, captured check and kind digits, result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.idx_clr) begin
      calc_q <= '0;
    end else if (sum_pend_q) begin
      calc_q <= mode_q ? (calc_q + rdata) : (calc_q ^ rdata);
    end
    case (cmd_i.cap)
      CAP_RHI: rhi_q  <= rd_nib;
      CAP_RLO: recv_q <= {rhi_q, rd_nib};
      CAP_KHI: khi_q  <= rd_nib;
      CAP_KLO: kind_q <= {khi_q, rd_nib};
      default: begin
      end
    endcase
    if (cmd_i.accept && item_emit) begin
      oev_q   <= item_ev;
      opay_q  <= '0;
      okind_q <= '0;
      olast_q <= 1'b1;
    end else if (cmd_i.out_single) begin
      oev_q   <= cmd_i.out_ev;
      opay_q  <= '0;
      okind_q <= (cmd_i.out_ev == EV_KIND) ? kind_q : '0;
      olast_q <= 1'b1;
    end else if (cmd_i.out_payload) begin
      oev_q   <= EV_PAYLOAD;
      opay_q  <= rdata;
      okind_q <= kind_q;
      olast_q <= sts_o.pay_last;
    end
  end

  assign out_valid_o    = ov_q;
  assign event_res_o    = oev_q;
  assign payload_byte_o = opay_q;
  assign kind_id_o      = okind_q;
  assign last_o         = olast_q;

endmodule
`default_nettype wire

FILE: hw/rtl/stx_cr_frame_receiver_core.sv
`default_nettype none
// ACK, NAK, timeout and overflow results are loaded at the edge that takes the item.
// A CR item starts a frame walk (n = stored bytes, STX and CR included): a short frame is
// reported; else bytes 1 to n-4 are folded into the check, the check and kind digits read,
// then the check or kind verdict given, or each payload byte read and then loaded.
// No item is taken during the walk; an item is taken in idle whenever the result register
// is empty or being emptied. Reset (rst_ni low, asynchronous) returns to idle with an empty
// result register, check_mode 0 and timeout_ticks 1000; the frame store is not cleared.
module stx_cr_frame_receiver_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [stxcr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [stxcr_pkg::CFG_W-1:0]     cfg_data_i,
  stxcr_item_if.sink                      item_i,
  stxcr_res_if.source                     result_o
);
  import stxcr_pkg::*;

  // Command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // Sequencer: owns the input handshake and the frame-end walk
  stxcr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(item_i.valid),
    .in_ready_o(item_i.ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Datapath: frame tracking, frame store, block check, kind lookup, result register
  stxcr_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .op_i          (item_i.op),
    .rx_byte_i     (item_i.rx_byte),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (result_o.valid),
    .out_ready_i   (result_o.ready),
    .event_res_o   (result_o.event_res),
    .payload_byte_o(result_o.payload_byte),
    .kind_id_o     (result_o.kind_id),
    .last_o        (result_o.last)
  );

endmodule
`default_nettype wire

FILE: bench/stx_cr_frame_receiver_core_tb.sv
`timescale 1ns / 1ps

module stx_cr_frame_receiver_core_tb;
  import stxcr_pkg::*;

  // Spare operation code: the block must ignore it
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  // Post-drain settle before the registers change or the run ends
  localparam int SETTLE_CYCLES = 2 * BUF_SIZE;
  localparam int LIMIT_NS      = 5_000_000;
  localparam logic [BYTE_W-1:0] CH_ETX = 8'h03;

  typedef struct packed {
    logic [EV_W-1:0]   ev;
    logic [BYTE_W-1:0] payload;
    logic [BYTE_W-1:0] kind;
    logic              last;
  } rx_event_t;

  typedef enum int {FR_GOOD, FR_BAD_CHECK, FR_BAD_KIND} frame_fault_e;
  typedef enum int {CUT_SHORT, CUT_LINE, CUT_TIMER} stub_end_e;

  // Receiver model: mirrors frame state and queues the events each transaction causes
  class rx_event_scoreboard;
    bit                check_mode;
    bit [TMR_W-1:0]    timeout_ticks;
    bit                receiving;
    int                fill;
    bit [BYTE_W-1:0]   frame_mem [BUF_SIZE];
    bit [TMR_W-1:0]    tick_count;
    rx_event_t         due_q [$];
    int                errors;

    function new();
      check_mode    = 1'b0;
      timeout_ticks = TIMEOUT_RST;
      receiving     = 1'b0;
      fill          = 0;
      tick_count    = '0;
      errors        = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == CFG_CHECK_MODE) begin
        check_mode = data[0];
      end else begin
        timeout_ticks = data;
      end
    endfunction

    function int due_count();
      return due_q.size();
    endfunction

    function void due(logic [EV_W-1:0] ev, logic [BYTE_W-1:0] pay,
                      logic [BYTE_W-1:0] kind, logic last);
      rx_event_t e;
      e.ev      = ev;
      e.payload = pay;
      e.kind    = kind;
      e.last    = last;
      due_q.push_back(e);
    endfunction

    function void drop_frame();
      receiving  = 1'b0;
      fill       = 0;
      tick_count = '0;
    endfunction

    // Non-hex characters read as zero
    function bit [3:0] digit(bit [BYTE_W-1:0] c);
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
      if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
      return 4'd0;
    endfunction

    function void apply_item(logic [OP_W-1:0] op, logic [BYTE_W-1:0] b);
      int n;
      bit [BYTE_W-1:0] calc, got, kind;
      case (op)
        OP_LERR: drop_frame();
        OP_TICK: begin
          if (receiving) begin
            tick_count++;
            if (tick_count >= timeout_ticks) begin
              drop_frame();
              due(EV_TIMEOUT, '0, '0, 1'b1);
            end
          end
        end
        OP_BYTE: begin
          if (!receiving) begin
            if (b == CH_STX) begin
              frame_mem[0] = b;
              fill         = 1;
              tick_count   = '0;
              receiving    = 1'b1;
            end else if (b == CH_ACK) begin
              due(EV_ACK, '0, '0, 1'b1);
            end else if (b == CH_NAK) begin
              due(EV_NAK, '0, '0, 1'b1);
            end
          end else if (fill >= BUF_SIZE) begin
            drop_frame();
            due(EV_OVERFLOW, '0, '0, 1'b1);
          end else begin
            frame_mem[fill] = b;
            fill++;
            if (b == CH_CR) begin
              n = fill;
              drop_frame();
              if (n < int'(MIN_FRAME)) begin
                due(EV_SHORT, '0, '0, 1'b1);
              end else begin
                calc = '0;
                for (int i = 1; i <= n - int'(CHK_END_OFS); i++) begin
                  calc = check_mode ? calc + frame_mem[i] : calc ^ frame_mem[i];
                end
                got  = {digit(frame_mem[n - int'(RHI_OFS)]),
                        digit(frame_mem[n - int'(RLO_OFS)])};
                kind = {digit(frame_mem[KIND_HI_POS]), digit(frame_mem[KIND_LO_POS])};
                if (calc != got) begin
                  due(EV_CHECK, '0, '0, 1'b1);
                end else if (!KIND_EN[kind[7:4]][kind[3:0]]) begin
                  due(EV_KIND, '0, kind, 1'b1);
                end else begin
                  for (int i = 1; i <= n - int'(PAY_END_OFS); i++) begin
                    due(EV_PAYLOAD, frame_mem[i], kind, i == n - int'(PAY_END_OFS));
                  end
                end
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(rx_event_t got);
      rx_event_t want;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing outstanding, expected none actual %h", $time, got);
        return;
      end
      want = due_q.pop_front();
      if (got.ev != want.ev) begin
        errors++;
        $display("%0t: event_res expected %0d actual %0d", $time, want.ev, got.ev);
      end
      if (got.payload != want.payload) begin
        errors++;
        $display("%0t: payload_byte expected %h actual %h", $time, want.payload, got.payload);
      end
      if (got.kind != want.kind) begin
        errors++;
        $display("%0t: kind_id expected %h actual %h", $time, want.kind, got.kind);
      end
      if (got.last != want.last) begin
        errors++;
        $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
      end
    endfunction
  endclass

  logic                 clk_i  = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  stxcr_item_if item_ch ();
  stxcr_res_if  res_ch ();

  stx_cr_frame_receiver_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_ch),
    .result_o   (res_ch)
  );

  rx_event_scoreboard sb;
  // Set while both sides run back to back with no idle cycles
  bit steady;
  int items_sent;

  always #5 clk_i = ~clk_i;

  // Hard stop should the block hang
  initial begin
    #(LIMIT_NS);
    $display("FAIL");
    $finish;
  end

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [BYTE_W-1:0] pick_data_byte();
    logic [BYTE_W-1:0] b;
    do b = rand_byte(); while (b == CH_CR);
    return b;
  endfunction

  // ASCII hex digit, case drawn at random
  function automatic logic [BYTE_W-1:0] hex_char(logic [3:0] nib);
    if (nib < 10) return 8'(8'h30 + nib);
    return 8'(($urandom_range(0, 1) ? "A" : "a") + nib - 10);
  endfunction

  // Mostly short payloads; the odd one up to a full store
  function automatic int pick_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(4, 59) : $urandom_range(4, 10);
  endfunction

  // Offer one item, hold it until the transaction completes, then note it.
  // Valid stays high on completion so a back-to-back item needs no re-raise.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_ch.valid   <= 1'b1;
    item_ch.op      <= op;
    item_ch.rx_byte <= b;
    do @(posedge clk_i); while (!item_ch.ready);
    sb.apply_item(op, b);
    items_sent++;
  endtask

  // Hold the sender until every outstanding result has been taken
  task automatic drain();
    item_ch.valid <= 1'b0;
    do @(posedge clk_i); while (sb.due_count() != 0);
  endtask

  // Reprogram both registers with the receiver idle
  task automatic set_regs(input bit mode, input logic [TMR_W-1:0] ticks);
    if (sb.receiving) send_item(OP_LERR, rand_byte());
    drain();
    // Let any walk that produced no result finish before touching the registers
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_CHECK_MODE;
    cfg_data_i <= CFG_W'(mode);
    @(posedge clk_i);
    sb.write_reg(CFG_CHECK_MODE, CFG_W'(mode));
    cfg_idx_i  <= CFG_TIMEOUT;
    cfg_data_i <= ticks;
    @(posedge clk_i);
    sb.write_reg(CFG_TIMEOUT, ticks);
    cfg_we_i   <= 1'b0;
  endtask

  // Well-formed frame: STX, payload with kind id at offsets 3 and 4, ETX (now and then a data byte),
  // two check characters, CR. A fault spoils the check or the kind.
  task automatic send_frame(input int pay_len, input frame_fault_e fault, input bit with_ticks);
    logic [BYTE_W-1:0] fb [$];
    logic [BYTE_W-1:0] kind, chk;
    int ticks;
    fb = {};
    fb.push_back(CH_STX);
    for (int i = 1; i <= pay_len; i++) fb.push_back(pick_data_byte());
    if (fault == FR_BAD_KIND && $urandom_range(0, 2) == 0) begin
      // Non-hex kind characters decode to id zero, which is disabled
      fb[3] = 8'("G" + $urandom_range(0, 19));
      fb[4] = 8'("g" + $urandom_range(0, 19));
    end else begin
      do kind = rand_byte();
      while (KIND_EN[kind[7:4]][kind[3:0]] == (fault == FR_BAD_KIND));
      fb[3] = hex_char(kind[7:4]);
      fb[4] = hex_char(kind[3:0]);
    end
    fb.push_back(($urandom_range(0, 7) == 0) ? pick_data_byte() : CH_ETX);
    chk = '0;
    for (int i = 1; i < fb.size(); i++) chk = sb.check_mode ? chk + fb[i] : chk ^ fb[i];
    if (fault == FR_BAD_CHECK) chk ^= 8'($urandom_range(1, 255));
    if (chk == 0 && $urandom_range(0, 1)) begin
      // A zero check may also be sent as non-hex characters
      fb.push_back(8'("G" + $urandom_range(0, 19)));
      fb.push_back(8'("x"));
    end else begin
      fb.push_back(hex_char(chk[7:4]));
      fb.push_back(hex_char(chk[3:0]));
    end
    fb.push_back(CH_CR);
    ticks = 0;
    foreach (fb[i]) begin
      // Sprinkle ticks inside the frame, always short of the timeout
      if (with_ticks && i > 0 && $urandom_range(0, 3) == 0 &&
          ticks + 1 < int'(sb.timeout_ticks)) begin
        send_item(OP_TICK, rand_byte());
        ticks++;
      end
      send_item(OP_BYTE, fb[i]);
    end
  endtask

  // Frame that never completes normally: cut short by CR, a line error or the timer
  task automatic send_stub(input stub_end_e ending);
    int k, n;
    k = $urandom_range(0, 6);
    send_item(OP_BYTE, CH_STX);
    repeat (k) send_item(OP_BYTE, pick_data_byte());
    if (ending == CUT_SHORT) begin
      send_item(OP_BYTE, CH_CR);
    end else if (ending == CUT_TIMER && sb.timeout_ticks <= 16) begin
      n = (sb.timeout_ticks == 0) ? 1 : int'(sb.timeout_ticks);
      repeat (n) send_item(OP_TICK, rand_byte());
    end else begin
      send_item(OP_LERR, rand_byte());
    end
  endtask

  // Fill the store to the brim, then push one more byte over the edge
  task automatic send_overflow();
    send_item(OP_BYTE, CH_STX);
    repeat (BUF_SIZE - 1) send_item(OP_BYTE, pick_data_byte());
    send_item(OP_BYTE, rand_byte());
  endtask

  task automatic run_traffic(input int budget);
    int start, pick;
    start = items_sent;
    while (items_sent - start < budget) begin
      steady = ($urandom_range(0, 4) == 0);
      pick   = $urandom_range(0, 99);
      if (pick < 40 || pick >= 94) begin
        send_frame(pick_len(), FR_GOOD, pick < 20);
      end else if (pick < 48) begin
        send_frame(pick_len(), FR_BAD_CHECK, 1'b0);
      end else if (pick < 56) begin
        send_frame(pick_len(), FR_BAD_KIND, 1'b1);
      end else if (pick < 64) begin
        send_stub(CUT_SHORT);
      end else if (pick < 71) begin
        send_item(OP_BYTE, $urandom_range(0, 1) ? CH_ACK : CH_NAK);
      end else if (pick < 78) begin
        send_item(OP_W'($urandom_range(0, 3)), rand_byte());
      end else if (pick < 84) begin
        send_stub(CUT_LINE);
      end else if (pick < 90) begin
        send_stub(CUT_TIMER);
      end else if (pick < 91) begin
        send_overflow();
      end else begin
        drain();
      end
    end
  endtask

  // Result side: stall a random while per result, then take and check it
  initial begin : result_sink
    int stall;
    rx_event_t got;
    res_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
      got.ev      = res_ch.event_res;
      got.payload = res_ch.payload_byte;
      got.kind    = res_ch.kind_id;
      got.last    = res_ch.last;
      sb.check_result(got);
    end
  end

  initial begin : stimulus
    sb         = new();
    items_sent = 0;
    steady     = 1'b0;
    item_ch.valid   <= 1'b0;
    item_ch.op      <= OP_BYTE;
    item_ch.rx_byte <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= CFG_CHECK_MODE;
    cfg_data_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: spare op, idle tick and line error, junk bytes, ACK, NAK,
    // two short frames, then a minimum-length good frame
    send_item(OP_SPARE, 8'hFF);
    send_item(OP_TICK, 8'hFF);
    send_item(OP_LERR, 8'h00);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, CH_ACK);
    send_item(OP_BYTE, CH_NAK);
    send_item(OP_BYTE, CH_STX);
    send_item(OP_BYTE, CH_CR);
    send_item(OP_BYTE, CH_STX);
    repeat (6) send_item(OP_BYTE, pick_data_byte());
    send_item(OP_BYTE, CH_CR);
    send_frame(4, FR_GOOD, 1'b0);
    run_traffic(25);

    // Sum check, timeout on the first tick
    set_regs(1'b1, 16'd1);
    send_stub(CUT_TIMER);
    run_traffic(20);

    set_regs(1'b0, 16'd4);
    send_stub(CUT_TIMER);
    run_traffic(20);

    // Timer out of reach: overflow and the longest accepted frame
    set_regs(1'b1, 16'hFFFF);
    send_overflow();
    send_frame(BUF_SIZE - int'(PAY_END_OFS), FR_GOOD, 1'b1);
    run_traffic(15);

    // Zero timeout: any tick in a frame expires it
    set_regs(1'b0, 16'd0);
    send_stub(CUT_TIMER);
    run_traffic(15);

    set_regs(1'b1, 16'd7);
    run_traffic(20);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.due_count() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
